// ----- hw/rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes of the bounded deque engine: command and result
// words, command codes and status codes.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DATA_W       = 32;
	localparam int MODE_W       = 4;
	localparam int K_W          = 6;
	localparam int SIZE_W       = 6;
	localparam int STAT_W       = 2;
	localparam int RESULT_LIMIT = 32;

	// command codes
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_REMOVE     = 4'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd5;
	localparam logic [MODE_W-1:0] MODE_FIRST_K    = 4'd6;
	localparam logic [MODE_W-1:0] MODE_LAST_K     = 4'd7;
	localparam logic [MODE_W-1:0] MODE_ALL        = 4'd8;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] value;
		logic [K_W-1:0]           count_k;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] item_value;
		logic                     has_value;
		logic                     last_of_run;
		logic [STAT_W-1:0]        status;
		logic [SIZE_W-1:0]        size_now;
	} res_t;

endpackage

// ----- hw/rtl/bdq_if.sv -----
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channels of the bounded deque engine: command and result.
// ----------------------------------------------------------------------------
interface bdq_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [bdq_pkg::MODE_W-1:0]        mode;
	logic signed [bdq_pkg::DATA_W-1:0] value;
	logic [bdq_pkg::K_W-1:0]           count_k;

	modport source (output valid, mode, value, count_k, input ready);
	modport sink (input valid, mode, value, count_k, output ready);
endinterface

interface bdq_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [bdq_pkg::DATA_W-1:0] item_value;
	logic                              has_value;
	logic                              last_of_run;
	logic [bdq_pkg::STAT_W-1:0]        status;
	logic [bdq_pkg::SIZE_W-1:0]        size_now;

	modport source (output valid, item_value, has_value, last_of_run, status, size_now,
		input ready);
	modport sink (input valid, item_value, has_value, last_of_run, status, size_now,
		output ready);
endinterface

// ----- hw/rtl/bounded_deque_engine.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed 32-bit values kept in a circular RAM.
//
//   channel | dir | payload                                      | accepted
//   cmd     | in  | mode, value, count_k                         | valid && ready
//   res     | out | item_value, has_value, last_of_run, status,  | valid && ready
//           |     | size_now                                     |
//
// Remove-by-value walks every stored entry; emit commands read their n entries
// in turn. The single read port of the entry RAM reads one entry per cycle,
// and during an emit only while the result sink takes the words.
// Reset clears head and size; the RAM needs no clearing pass.
// A stalled result sink holds the sequencer once the output register is full.
// ----------------------------------------------------------------------------
module bounded_deque_engine #(
	parameter int CAPACITY = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	bdq_cmd_if.sink  cmd,
	bdq_res_if.source res
);
	import bdq_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	cmd_t              cmd_word;
	res_t              seq_word;
	res_t              out_word;
	logic              seq_valid;
	logic              seq_ready;
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [IW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	// pack the command word
	assign cmd_word.mode    = cmd.mode;
	assign cmd_word.value   = cmd.value;
	assign cmd_word.count_k = cmd.count_k;

	bdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bdq_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.cmd       (cmd_word),
		.res_valid (seq_valid),
		.res_ready (seq_ready),
		.res       (seq_word),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bdq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seq_valid),
		.in_ready  (seq_ready),
		.in_word   (seq_word),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_word  (out_word)
	);

	// unpack the result word
	assign res.item_value  = out_word.item_value;
	assign res.has_value   = out_word.has_value;
	assign res.last_of_run = out_word.last_of_run;
	assign res.status      = out_word.status;
	assign res.size_now    = out_word.size_now;

endmodule

// ----- hw/rtl/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds until the next read.
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/bdq_seq.sv -----
// ----------------------------------------------------------------------------
// bdq_seq
// Command sequencer: keeps head and size, drives the entry RAM, walks the
// stored entries for remove and emit commands and forms result words.
// ----------------------------------------------------------------------------
module bdq_seq #(
	parameter int CAPACITY = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  bdq_pkg::cmd_t                   cmd,
	output logic                            res_valid,
	input  logic                            res_ready,
	output bdq_pkg::res_t                   res,
	output logic                            mem_we,
	output logic [$clog2(CAPACITY)-1:0]     mem_waddr,
	output logic [bdq_pkg::DATA_W-1:0]      mem_wdata,
	output logic                            mem_re,
	output logic [$clog2(CAPACITY)-1:0]     mem_raddr,
	input  logic [bdq_pkg::DATA_W-1:0]      mem_rdata
);
	import bdq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;

	typedef enum logic [1:0] {S_IDLE, S_RESP, S_SCAN, S_EMIT} state_t;

	state_t              state_q;
	logic [IW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       rd_addr_q;
	logic [IW-1:0]       wr_addr_q;
	logic [CW-1:0]       rd_left_q;
	logic [CW-1:0]       out_left_q;
	logic [CW-1:0]       keep_q;
	logic                pend_q;
	logic [DATA_W-1:0]   val_q;
	logic [STAT_W-1:0]   stat_q;

	logic [7:0]          k8;
	logic [7:0]          c8;
	logic                full;
	logic                is_push;
	logic [CW-1:0]       n_sel;
	logic [CW-1:0]       start_sel;
	logic [CW-1:0]       n_lim;
	logic [CW-1:0]       start_lim;
	logic [CW-1:0]       count_m1;
	logic [IW-1:0]       prev_head;
	logic                take;
	logic                push_out;
	logic                keep_hit;

	// wrap an offset from the head onto a store address
	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
		input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(head) + SW'(off);
		if (s >= SW'(CAPACITY)) begin
			s = s - SW'(CAPACITY);
		end
		return IW'(s);
	endfunction

	function automatic logic [IW-1:0] next_addr(input logic [IW-1:0] a);
		return (a == IW'(CAPACITY - 1)) ? '0 : a + 1'b1;
	endfunction

	// fullness, push decode, neighbour slot, and size and range of an emit command
	always_comb begin
		k8        = 8'(cmd.count_k);
		c8        = 8'(count_q);
		full      = c8 >= 8'(CAPACITY);
		is_push   = (cmd.mode == MODE_PUSH_FRONT) || (cmd.mode == MODE_PUSH_BACK);
		count_m1  = count_q - 1'b1;
		prev_head = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - 1'b1;
		n_sel     = (cmd.mode == MODE_ALL || k8 >= c8) ? count_q : CW'(cmd.count_k);
		start_sel = (cmd.mode == MODE_LAST_K) ? count_q - n_sel : '0;
		if (8'(n_sel) > 8'(RESULT_LIMIT)) begin
			start_lim = start_sel + (n_sel - CW'(RESULT_LIMIT));
			n_lim     = CW'(RESULT_LIMIT);
		end else begin
			start_lim = start_sel;
			n_lim     = n_sel;
		end
	end

	// handshakes and RAM read issue
	assign cmd_ready = (state_q == S_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign push_out  = (state_q == S_EMIT) && pend_q && res_ready;
	assign mem_re    = (rd_left_q != '0) &&
		((state_q == S_SCAN) || ((state_q == S_EMIT) && (!pend_q || push_out)));
	assign mem_raddr = rd_addr_q;
	assign keep_hit  = (state_q == S_SCAN) && pend_q && (mem_rdata != val_q);

	// RAM write: pushes on accept, compaction during a scan
	always_comb begin
		if (state_q == S_SCAN) begin
			mem_we    = keep_hit;
			mem_waddr = wr_addr_q;
			mem_wdata = mem_rdata;
		end else begin
			mem_we    = take && is_push && !full;
			mem_waddr = (cmd.mode == MODE_PUSH_FRONT) ? prev_head : slot_of(head_q, count_q);
			mem_wdata = cmd.value;
		end
	end

	// result word
	always_comb begin
		res.size_now = SIZE_W'(count_q);
		if (state_q == S_EMIT) begin
			res.item_value  = mem_rdata;
			res.has_value   = 1'b1;
			res.last_of_run = (out_left_q == CW'(1));
			res.status      = STAT_OK;
		end else begin
			res.item_value  = '0;
			res.has_value   = 1'b0;
			res.last_of_run = 1'b1;
			res.status      = stat_q;
		end
	end
	assign res_valid = (state_q == S_RESP) || ((state_q == S_EMIT) && pend_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			rd_left_q  <= '0;
			out_left_q <= '0;
			pend_q     <= 1'b0;
			stat_q     <= STAT_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						val_q   <= cmd.value;
						stat_q  <= STAT_OK;
						state_q <= S_RESP;
						pend_q  <= 1'b0;
						unique case (cmd.mode)
							MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
								if (full) begin
									stat_q <= STAT_FULL;
								end else begin
									count_q <= count_q + 1'b1;
									if (cmd.mode == MODE_PUSH_FRONT) begin
										head_q <= prev_head;
									end
								end
							end
							MODE_POP_FRONT, MODE_POP_BACK: begin
								if (count_q == '0) begin
									stat_q <= STAT_EMPTY;
								end else begin
									count_q    <= count_m1;
									rd_left_q  <= CW'(1);
									out_left_q <= CW'(1);
									state_q    <= S_EMIT;
									if (cmd.mode == MODE_POP_FRONT) begin
										rd_addr_q <= head_q;
										head_q    <= next_addr(head_q);
									end else begin
										rd_addr_q <= slot_of(head_q, count_m1);
									end
								end
							end
							MODE_REMOVE: begin
								rd_addr_q <= head_q;
								wr_addr_q <= head_q;
								rd_left_q <= count_q;
								keep_q    <= '0;
								state_q   <= S_SCAN;
							end
							MODE_CLEAR: begin
								count_q <= '0;
							end
							MODE_FIRST_K, MODE_LAST_K, MODE_ALL: begin
								if (count_q == '0) begin
									stat_q <= STAT_EMPTY;
								end else if (n_lim != '0) begin
									rd_addr_q  <= slot_of(head_q, start_lim);
									rd_left_q  <= n_lim;
									out_left_q <= n_lim;
									state_q    <= S_EMIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					// read one entry a cycle, write back the ones that stay
					if (mem_re) begin
						rd_addr_q <= next_addr(rd_addr_q);
						rd_left_q <= rd_left_q - 1'b1;
					end
					pend_q <= mem_re;
					if (keep_hit) begin
						wr_addr_q <= next_addr(wr_addr_q);
						keep_q    <= keep_q + 1'b1;
					end
					if (!pend_q && rd_left_q == '0) begin
						count_q <= keep_q;
						state_q <= S_RESP;
					end
				end
				S_EMIT: begin
					// hold read data until the output stage takes it
					if (mem_re) begin
						rd_addr_q <= next_addr(rd_addr_q);
						rd_left_q <= rd_left_q - 1'b1;
						pend_q    <= 1'b1;
					end else if (push_out) begin
						pend_q <= 1'b0;
					end
					if (push_out) begin
						out_left_q <= out_left_q - 1'b1;
						if (out_left_q == CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/bdq_out.sv -----
// ----------------------------------------------------------------------------
// bdq_out
// Output register of the result channel: holds one word; once it is full and
// the sink stalls, the sequencer is held.
// ----------------------------------------------------------------------------
module bdq_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bdq_pkg::res_t in_word,
	output logic          out_valid,
	input  logic          out_ready,
	output bdq_pkg::res_t out_word
);
	import bdq_pkg::*;

	logic valid_q;
	res_t word_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	// load a new word when the held one leaves or none is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= in_word;
		end
	end

endmodule

// ----- hw/rtl/bdq_checker.sv -----
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the bounded deque engine's result channel, bound to
// the top level.
// ----------------------------------------------------------------------------
module bdq_checker #(
	parameter int CAPACITY = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] item_value,
	input logic        has_value,
	input logic        last_of_run,
	input logic [1:0]  status,
	input logic [5:0]  size_now
);
	import bdq_pkg::*;

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(item_value) && $stable(has_value)
			&& $stable(last_of_run) && $stable(status) && $stable(size_now))
		else $error("result word changed while stalled");

	// a word without an entry always closes its command and carries a zero value
	a_bare_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !has_value |-> last_of_run && item_value == '0)
		else $error("bare result not final or value not zero");

	// error status comes alone, entries only with ok status
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && has_value |-> status == STAT_OK)
		else $error("entry carried with error status");

	// empty status only with an empty queue
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == STAT_EMPTY |-> size_now == '0)
		else $error("empty status with entries present");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (CAPACITY >= 64) || (32'(size_now) <= 32'(CAPACITY)))
		else $error("size above capacity");

endmodule

bind bounded_deque_engine bdq_checker #(
	.CAPACITY (CAPACITY)
) u_bdq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.item_value  (res.item_value),
	.has_value   (res.has_value),
	.last_of_run (res.last_of_run),
	.status      (res.status),
	.size_now    (res.size_now)
);
